// ----- sv/dac_pkg.sv -----
package dac_pkg;

	// fixed field widths
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned LIMIT_W = 28;
	localparam int unsigned CENTS_W = 35;
	localparam int unsigned MDATA_W = 40;

	// defaults
	localparam int unsigned DEF_MAX_FRAC_DIGITS = 2;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 28'd200000000;

	// character codes
	localparam logic [SYM_W-1:0] DOT_CHAR  = 8'h2e;
	localparam logic [SYM_W-1:0] ZERO_CHAR = 8'h30;
	localparam logic [SYM_W-1:0] NINE_CHAR = 8'h39;

	// character class of one symbol
	typedef struct packed {
		logic       is_dot;
		logic       is_digit;
		logic [3:0] digit;
	} dac_class_t;

	function automatic dac_class_t classify(input logic [SYM_W-1:0] sym);
		dac_class_t c;
		logic [SYM_W-1:0] off;
		off        = sym - ZERO_CHAR;
		c.is_dot   = (sym == DOT_CHAR);
		c.is_digit = (sym >= ZERO_CHAR) && (sym <= NINE_CHAR);
		c.digit    = off[3:0];
		return c;
	endfunction

endpackage

// ----- sv/dac_parse.sv -----
module dac_parse import dac_pkg::*; #(
	parameter int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
	localparam int unsigned FRAC_W = $clog2(10**MAX_FRAC_DIGITS),
	localparam int unsigned CNT_W  = $clog2(MAX_FRAC_DIGITS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               last,
	input  logic [SYM_W-1:0]   sym,
	input  logic [LIMIT_W-1:0] limit,
	output logic [LIMIT_W-1:0] whole,
	output logic [FRAC_W-1:0]  frac,
	output logic [CNT_W-1:0]   count,
	output logic               ok
);

	localparam int unsigned NEXT_W = LIMIT_W + 4;

	logic [LIMIT_W-1:0] whole_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [CNT_W-1:0]   count_q;
	logic               dot_q;
	logic               failed_q;
	logic               nonempty_q;

	dac_class_t         cls;
	logic [NEXT_W-1:0]  whole_next;
	logic [FRAC_W+3:0]  frac_next;

	// character class and candidate accumulator values
	always_comb begin
		cls        = classify(sym);
		whole_next = NEXT_W'({whole_q, 3'b000}) + NEXT_W'({whole_q, 1'b0})
			+ NEXT_W'(cls.digit);
		frac_next  = (FRAC_W+4)'({frac_q, 3'b000}) + (FRAC_W+4)'({frac_q, 1'b0})
			+ (FRAC_W+4)'(cls.digit);
	end

	// parse state, cleared after every end of text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			whole_q    <= '0;
			frac_q     <= '0;
			count_q    <= '0;
			dot_q      <= 1'b0;
			failed_q   <= 1'b0;
			nonempty_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				whole_q    <= '0;
				frac_q     <= '0;
				count_q    <= '0;
				dot_q      <= 1'b0;
				failed_q   <= 1'b0;
				nonempty_q <= 1'b0;
			end else begin
				nonempty_q <= 1'b1;
				if (!failed_q) begin
					if (cls.is_dot) begin
						if (dot_q)
							failed_q <= 1'b1;
						else
							dot_q <= 1'b1;
					end else if (!cls.is_digit) begin
						failed_q <= 1'b1;
					end else if (!dot_q) begin
						// limit check after each whole digit
						if (whole_next > NEXT_W'(limit))
							failed_q <= 1'b1;
						else
							whole_q <= whole_next[LIMIT_W-1:0];
					end else if (count_q < CNT_W'(MAX_FRAC_DIGITS)) begin
						frac_q  <= frac_next[FRAC_W-1:0];
						count_q <= count_q + CNT_W'(1);
					end else begin
						failed_q <= 1'b1;
					end
				end
			end
		end
	end

	assign whole = whole_q;
	assign frac  = frac_q;
	assign count = count_q;
	assign ok    = nonempty_q && !failed_q;

endmodule

// ----- sv/dac_result.sv -----
module dac_result import dac_pkg::*; #(
	parameter int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
	localparam int unsigned FRAC_W = $clog2(10**MAX_FRAC_DIGITS),
	localparam int unsigned CNT_W  = $clog2(MAX_FRAC_DIGITS + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [LIMIT_W-1:0] whole,
	input  logic [FRAC_W-1:0]  frac,
	input  logic [CNT_W-1:0]   count,
	input  logic               ok,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [MDATA_W-1:0] m_tdata,
	output logic               m_tuser
);

	localparam int unsigned SCALE_W = $clog2(10**MAX_FRAC_DIGITS + 1);
	localparam int unsigned SUM_W   = LIMIT_W + SCALE_W + 1;

	logic [SCALE_W-1:0]        fscale;
	logic [FRAC_W+SCALE_W-1:0] frac_prod;
	logic [SUM_W-1:0]          whole_prod;
	logic [SUM_W-1:0]          sum;
	logic [CENTS_W-1:0]        cents;

	logic                      valid_q;
	logic [CENTS_W-1:0]        cents_q;
	logic                      ok_q;

	// fraction scale by digits still missing
	always_comb begin
		fscale = '0;
		for (int k = 0; k <= MAX_FRAC_DIGITS; k++) begin
			if (count == CNT_W'(k))
				fscale = SCALE_W'(10**(MAX_FRAC_DIGITS - k));
		end
	end

	// whole times full scale plus scaled fraction, zero for a text that is not ok
	always_comb begin
		frac_prod  = (FRAC_W+SCALE_W)'(frac) * (FRAC_W+SCALE_W)'(fscale);
		whole_prod = SUM_W'(whole) * SUM_W'(10**MAX_FRAC_DIGITS);
		sum        = whole_prod + SUM_W'(frac_prod);
		cents      = ok ? CENTS_W'(sum) : '0;
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (load)
			valid_q <= 1'b1;
		else if (m_tready)
			valid_q <= 1'b0;
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			cents_q <= cents;
			ok_q    <= ok;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = MDATA_W'(cents_q);
	assign m_tuser  = ok_q;

endmodule

// ----- sv/decimal_amount_to_cents.sv -----
// channel   | direction | signals                              | contents
// s_        | in        | s_tvalid s_tready s_tdata s_tlast    | one character, end of text
// m_        | out       | m_tvalid m_tready m_tdata m_tuser    | cents, valid flag
// cfg_      | in        | cfg_valid cfg_ready cfg_data         | whole-unit limit
//
// one character per cycle while no end of text waits on a stalled result;
// each item passes an input register, then the parse update, and on end of
// text the scaling into the output register, where the result turns valid.
// reset clears parse state and sets the limit to 200000000.
// a stalled result holds only an end of text in the input register; characters
// keep flowing while the result waits, until the next end of text is held.
module decimal_amount_to_cents import dac_pkg::*; #(
	parameter int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [SYM_W-1:0]   s_tdata,   // [7:0] symbol
	input  logic               s_tlast,   // end_of_text
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [MDATA_W-1:0] m_tdata,   // [34:0] cents, [39:35] zero
	output logic               m_tuser,   // [0] valid_res
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] cfg_data
);

	localparam int unsigned FRAC_W = $clog2(10**MAX_FRAC_DIGITS);
	localparam int unsigned CNT_W  = $clog2(MAX_FRAC_DIGITS + 1);

	logic               valid_s1;
	logic [SYM_W-1:0]   sym_s1;
	logic               last_s1;
	logic [LIMIT_W-1:0] limit_q;

	logic               out_stall;
	logic               advance;
	logic [LIMIT_W-1:0] whole;
	logic [FRAC_W-1:0]  frac;
	logic [CNT_W-1:0]   count;
	logic               ok;

	// limit register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= LIMIT_RESET;
		else if (cfg_valid)
			limit_q <= cfg_data;
	end

	// input stage handshake
	assign out_stall = m_tvalid && !m_tready;
	assign advance   = valid_s1 && !(last_s1 && out_stall);
	assign s_tready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tvalid && s_tready)
			valid_s1 <= 1'b1;
		else if (advance)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			sym_s1  <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// per-character parse state
	dac_parse #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.last   (last_s1),
		.sym    (sym_s1),
		.limit  (limit_q),
		.whole  (whole),
		.frac   (frac),
		.count  (count),
		.ok     (ok)
	);

	// scaling and output register
	dac_result #(.MAX_FRAC_DIGITS(MAX_FRAC_DIGITS)) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && last_s1),
		.whole    (whole),
		.frac     (frac),
		.count    (count),
		.ok       (ok),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

// ----- sim/tb.sv -----
// expected amount for one end-of-text transfer
typedef struct {
	logic [dac_pkg::CENTS_W-1:0] cents;
	logic                        valid_res;
} amount_t;

// tracks the parse state and checks each returned amount
class cents_scoreboard;
	localparam int unsigned FRAC_DIGITS = dac_pkg::DEF_MAX_FRAC_DIGITS;

	amount_t               expected_amounts[$];
	logic [dac_pkg::LIMIT_W-1:0] whole_limit;
	logic [63:0]           whole_units;
	logic [31:0]           frac_units;
	int unsigned           frac_count;
	bit                    dot_seen;
	bit                    rejected;
	bit                    nonempty;
	int unsigned           mismatches;
	int unsigned           texts_ok;
	int unsigned           texts_bad;

	function new();
		whole_limit = dac_pkg::LIMIT_RESET;
		mismatches  = 0;
		texts_ok    = 0;
		texts_bad   = 0;
		clear_text();
	endfunction

	function void clear_text();
		whole_units = 0;
		frac_units  = 0;
		frac_count  = 0;
		dot_seen    = 0;
		rejected    = 0;
		nonempty    = 0;
	endfunction

	function void set_limit(input logic [dac_pkg::LIMIT_W-1:0] value);
		whole_limit = value;
	endfunction

	function int unsigned pending();
		return expected_amounts.size();
	endfunction

	function logic [63:0] pow10(input int unsigned n);
		logic [63:0] p;
		p = 1;
		for (int i = 0; i < n; i++)
			p = p * 10;
		return p;
	endfunction

	// one accepted input transfer
	function void note_symbol(input logic [dac_pkg::SYM_W-1:0] sym, input logic last);
		logic [63:0] next_whole;
		logic [3:0]  digit;
		amount_t     amt;
		if (last) begin
			amt.valid_res = nonempty && !rejected;
			amt.cents     = '0;
			if (amt.valid_res) begin
				next_whole = whole_units * pow10(FRAC_DIGITS)
					+ frac_units * pow10(FRAC_DIGITS - frac_count);
				amt.cents  = next_whole[dac_pkg::CENTS_W-1:0];
				texts_ok++;
			end else begin
				texts_bad++;
			end
			expected_amounts.push_back(amt);
			clear_text();
			return;
		end
		nonempty = 1;
		if (rejected)
			return;
		if (sym == dac_pkg::DOT_CHAR) begin
			if (dot_seen)
				rejected = 1;
			else
				dot_seen = 1;
		end else if (sym < dac_pkg::ZERO_CHAR || sym > dac_pkg::NINE_CHAR) begin
			rejected = 1;
		end else begin
			digit = 4'(sym - dac_pkg::ZERO_CHAR);
			if (!dot_seen) begin
				next_whole = whole_units * 10 + digit;
				if (next_whole > whole_limit)
					rejected = 1;
				else
					whole_units = next_whole;
			end else if (frac_count < FRAC_DIGITS) begin
				frac_units = frac_units * 10 + digit;
				frac_count++;
			end else begin
				rejected = 1;
			end
		end
	endfunction

	// one accepted result transfer
	function void check_result(input logic [dac_pkg::CENTS_W-1:0] cents,
		input logic valid_res);
		amount_t amt;
		if (expected_amounts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: cents %0d valid %0b", cents, valid_res);
			return;
		end
		amt = expected_amounts.pop_front();
		if (amt.cents !== cents || amt.valid_res !== valid_res) begin
			mismatches++;
			if (mismatches <= 10)
				$display("wrong result: expected cents %0d valid %0b, got cents %0d valid %0b",
					amt.cents, amt.valid_res, cents, valid_res);
		end
	endfunction
endclass

module tb;
	import dac_pkg::*;

	localparam int unsigned STALL_LIMIT  = 5000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_ITEMS  = 216;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [SYM_W-1:0]   s_tdata = '0;   // [7:0] symbol
	logic               s_tlast = 1'b0; // end_of_text
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [MDATA_W-1:0] m_tdata;        // [34:0] cents, [39:35] zero
	logic               m_tuser;        // [0] valid_res
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] cfg_data = '0;

	cents_scoreboard    sb;
	logic [SYM_W-1:0]   chars[$];
	logic [LIMIT_W-1:0] cur_limit = LIMIT_RESET;
	int unsigned        src_idle = 0;
	int unsigned        sink_stall = 0;
	int unsigned        items_sent = 0;
	int unsigned        quiet_cycles = 0;

	decimal_amount_to_cents dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall);
	end

	// watch every transfer at the edge
	always @(posedge clk) begin
		if (cfg_valid && cfg_ready)
			sb.set_limit(cfg_data);
		if (s_tvalid && s_tready)
			sb.note_symbol(s_tdata, s_tlast);
		if (m_tvalid && m_tready)
			sb.check_result(m_tdata[CENTS_W-1:0], m_tuser);
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// one character or end-of-text transfer, with random gaps before it
	task automatic send_item(input logic [SYM_W-1:0] sym, input logic last);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	// send the built text followed by its end item
	task automatic send_text();
		foreach (chars[i])
			send_item(chars[i], 1'b0);
		send_item(SYM_W'($urandom_range(255)), 1'b1);
		chars.delete();
	endtask

	// drain all results, then let the pipeline settle
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic [LIMIT_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_limit = value;
	endtask

	task automatic push_digit();
		chars.push_back(ZERO_CHAR + SYM_W'($urandom_range(9)));
	endtask

	task automatic push_number(input longint unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++)
			chars.push_back(SYM_W'(s[i]));
	endtask

	// optional leading zeros, digits, an optional dot and up to two fraction digits
	task automatic push_wellformed();
		int unsigned nd;
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(1, 3)) chars.push_back(ZERO_CHAR);
		nd = ($urandom_range(4) == 0) ? $urandom_range(9) : $urandom_range(3);
		repeat (nd) push_digit();
		if ($urandom_range(9) < 7) begin
			chars.push_back(DOT_CHAR);
			repeat ($urandom_range(2)) push_digit();
		end
	endtask

	// pick one random text: mostly well-formed, some near the limit, broken or noise
	task automatic build_text();
		int unsigned     kind;
		longint          w;
		int unsigned     pos;
		kind = $urandom_range(99);
		if (kind < 55) begin
			push_wellformed();
		end else if (kind < 70) begin
			// whole part just below, at or just above the limit
			w = longint'(cur_limit) + $urandom_range(2) - 1;
			if (w < 0)
				w = 0;
			if ($urandom_range(3) == 0)
				chars.push_back(ZERO_CHAR);
			push_number(w);
			if ($urandom_range(1)) begin
				chars.push_back(DOT_CHAR);
				repeat ($urandom_range(2)) push_digit();
			end
		end else if (kind < 95) begin
			push_wellformed();
			pos = $urandom_range(chars.size());
			case ($urandom_range(3))
				0: chars.insert(pos, SYM_W'($urandom_range(255)));
				1: chars.insert(pos, DOT_CHAR);
				2: begin
					chars.push_back(DOT_CHAR);
					repeat (3) push_digit();
				end
				default: chars.delete();
			endcase
		end else begin
			repeat ($urandom_range(1, 6)) chars.push_back(SYM_W'($urandom_range(255)));
		end
	endtask

	// short directed texts
	task automatic send_directed();
		// lone dot
		chars = '{DOT_CHAR};
		send_text();
		// dot with no digits after it
		chars = '{8'h35, DOT_CHAR};
		send_text();
		// one fraction digit is scaled by ten
		chars = '{8'h31, DOT_CHAR, 8'h35};
		send_text();
		// empty text
		send_text();
		// nul character
		chars = '{8'h00};
		send_text();
		// highest symbol code
		chars = '{8'hff};
		send_text();
		// second dot
		chars = '{DOT_CHAR, DOT_CHAR};
		send_text();
		// third fraction digit
		chars = '{ZERO_CHAR, DOT_CHAR, 8'h31, 8'h32, 8'h33};
		send_text();
	endtask

	typedef struct {
		logic [LIMIT_W-1:0] limit;
		int unsigned        src_pct;
		int unsigned        sink_pct;
	} phase_t;

	initial begin
		phase_t phases[8];
		sb = new();
		phases[0] = '{LIMIT_RESET, 0, 0};
		phases[1] = '{'0, 84, 0};
		phases[2] = '{LIMIT_RESET, 0, 84};
		phases[3] = '{LIMIT_W'($urandom_range(1, 200000000)), 22, 22};
		phases[4] = '{LIMIT_W'(99), 0, 0};
		phases[5] = '{LIMIT_W'(123456789), 84, 0};
		phases[6] = '{LIMIT_W'($urandom_range(1, 100000)), 0, 84};
		phases[7] = '{LIMIT_RESET, 22, 22};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset value of the limit is in effect for the directed texts
		send_directed();

		foreach (phases[p]) begin
			wait_idle();
			if (p != 0)
				write_limit(phases[p].limit);
			src_idle   = phases[p].src_pct;
			sink_stall = phases[p].sink_pct;
			items_sent = 0;
			while (items_sent < PHASE_ITEMS) begin
				build_text();
				send_text();
			end
		end

		wait_idle();
		$display("texts checked: %0d accepted, %0d rejected, over eight limit and flow settings",
			sb.texts_ok, sb.texts_bad);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
